// ----- rtl/distinct_value_sorter_assert.svh -----
`ifndef DISTINCT_VALUE_SORTER_ASSERT_SVH
`define DISTINCT_VALUE_SORTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DVS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DVS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/dvs_pkg.sv -----
package dvs_pkg;

  localparam int CAPACITY = 64;
  localparam int IN_W     = 32;
  localparam int VAL_W    = 31;
  localparam int OUT_W    = 32;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_EMPTY
  } state_t;

  typedef struct packed {
    logic             ins;
    logic             drain;
    logic [VAL_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ----- rtl/dvs_cell.sv -----
module dvs_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dvs_pkg::cell_ctrl_t           ctrl,
  input  logic                          left_less,
  input  logic [dvs_pkg::VAL_W-1:0]     left_val,
  input  logic                          left_valid,
  input  logic [dvs_pkg::VAL_W-1:0]     right_val,
  input  logic                          right_valid,
  output logic                          less,
  output logic                          eq,
  output logic [dvs_pkg::VAL_W-1:0]     val,
  output logic                          valid
);

  logic [dvs_pkg::VAL_W-1:0] val_r, val_nxt;
  logic                      valid_r, valid_nxt;

  assign less  = valid_r && (val_r < ctrl.value);
  assign eq    = valid_r && (val_r == ctrl.value);
  assign val   = val_r;
  assign valid = valid_r;

  always_comb begin
    val_nxt   = val_r;
    valid_nxt = valid_r;
    if (ctrl.ins && !less) begin
      if (left_less) begin
        val_nxt   = ctrl.value;
        valid_nxt = 1'b1;
      end else begin
        val_nxt   = left_val;
        valid_nxt = left_valid;
      end
    end else if (ctrl.drain) begin
      val_nxt   = right_val;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

// ----- rtl/distinct_value_sorter.sv -----
// Sorted set of distinct positive values held in a row of 64 compare-and-shift cells.
// Each positive value taken is compared by every cell against its own entry
// at once, a duplicate is discarded, and a new value is inserted in order by shifting the
// larger entries one cell to the right; with all cells full a new value is dropped and the
// overflow flag (tuser[1]) is raised for the run. A value of zero or less ends the load;
// the input then stalls while the set is read out in ascending order, one transfer per
// cycle while out_tready is high, as the row shifts toward cell 0, the final one with
// tlast. An empty set yields one result with tuser[0] set. After the last transfer the
// set is clear and loading resumes in the next cycle.
`include "distinct_value_sorter_assert.svh"

module distinct_value_sorter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [dvs_pkg::IN_W-1:0]     in_tdata,   // [31:0] value
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [dvs_pkg::OUT_W-1:0]    out_tdata,  // [30:0] sorted_value, [31] zero
  output logic                         out_tlast,  // last
  output logic [1:0]                   out_tuser   // [0] empty_res, [1] overflow
);

  localparam int N = dvs_pkg::CAPACITY;

  dvs_pkg::state_t     state_r, state_nxt;
  logic                dropped_r, dropped_nxt;
  dvs_pkg::cell_ctrl_t ctrl;

  logic [N-1:0]              less, eq, valid;
  logic [dvs_pkg::VAL_W-1:0] val [N];

  logic in_xfer, out_xfer, positive, dup, full;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;
  assign positive = !in_tdata[dvs_pkg::IN_W-1] && (in_tdata != '0);
  assign dup      = |eq;
  assign full     = valid[N-1];

  assign ctrl.value = in_tdata[dvs_pkg::VAL_W-1:0];
  assign ctrl.ins   = in_xfer && positive && !dup && !full;
  assign ctrl.drain = out_xfer && (state_r == dvs_pkg::ST_DRAIN);

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      logic                      l_less, l_valid, r_valid;
      logic [dvs_pkg::VAL_W-1:0] l_val, r_val;
      if (g == 0) begin : g_first
        assign l_less  = 1'b1;
        assign l_val   = '0;
        assign l_valid = 1'b0;
      end else begin : g_mid
        assign l_less  = less[g-1];
        assign l_val   = val[g-1];
        assign l_valid = valid[g-1];
      end
      if (g == N-1) begin : g_end
        assign r_val   = '0;
        assign r_valid = 1'b0;
      end else begin : g_inner
        assign r_val   = val[g+1];
        assign r_valid = valid[g+1];
      end
      dvs_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .left_less   (l_less),
        .left_val    (l_val),
        .left_valid  (l_valid),
        .right_val   (r_val),
        .right_valid (r_valid),
        .less        (less[g]),
        .eq          (eq[g]),
        .val         (val[g]),
        .valid       (valid[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dvs_pkg::ST_LOAD: begin
        if (in_xfer && !positive) begin
          state_nxt = valid[0] ? dvs_pkg::ST_DRAIN : dvs_pkg::ST_EMPTY;
        end
      end
      dvs_pkg::ST_DRAIN: begin
        if (out_xfer && !valid[1]) begin
          state_nxt = dvs_pkg::ST_LOAD;
        end
      end
      dvs_pkg::ST_EMPTY: begin
        if (out_xfer) begin
          state_nxt = dvs_pkg::ST_LOAD;
        end
      end
      default: state_nxt = dvs_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    out_tlast  = 1'b0;
    out_tdata  = '0;
    out_tuser  = {dropped_r, 1'b0};
    case (state_r)
      dvs_pkg::ST_LOAD: begin
        in_tready = 1'b1;
      end
      dvs_pkg::ST_DRAIN: begin
        out_tvalid = 1'b1;
        out_tlast  = !valid[1];
        out_tdata  = {1'b0, val[0]};
      end
      dvs_pkg::ST_EMPTY: begin
        out_tvalid = 1'b1;
        out_tlast  = 1'b1;
        out_tuser  = {dropped_r, 1'b1};
      end
      default: in_tready = 1'b0;
    endcase
  end

  always_comb begin
    dropped_nxt = dropped_r;
    if (out_xfer && out_tlast) begin
      dropped_nxt = 1'b0;
    end else if (in_xfer && positive && !dup && full) begin
      dropped_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= dvs_pkg::ST_LOAD;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  `DVS_ASSERT_NOW(a_one_side, out_tvalid, !in_tready, "input taken during readout")
  `DVS_ASSERT_NOW(a_packed, valid[1], valid[0], "gap in the cell row")
  `DVS_ASSERT_NOW(a_order, valid[1], val[0] < val[1], "cells out of order")
  `DVS_ASSERT_NEXT(a_clear, out_xfer && out_tlast, in_tready && !valid[0] && !dropped_r,
    "set not cleared after last transfer")

endmodule
